### sv/lennard_jones_pair_forces_defines.svh
// Assertion macros shared by the block's modules.
`ifndef LENNARD_JONES_PAIR_FORCES_DEFINES_SVH
`define LENNARD_JONES_PAIR_FORCES_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LJ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LJ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/lj_pkg.sv
package lj_pkg;

	localparam int MAX_PARTICLES_DEF = 1024;
	localparam int ACC_FRAC_BITS     = 32;
	localparam int OP_W              = 64;
	localparam int PROD_W            = 2 * OP_W;

	localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;

	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_COMPUTE = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	localparam logic [1:0] REG_COUNT  = 2'd0;
	localparam logic [1:0] REG_BOX    = 2'd1;
	localparam logic [1:0] REG_CUTOFF = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE,
		S_READ_OUT,
		S_PASS_INIT,
		S_MUL_GO,
		S_MUL_WAIT,
		S_PAIR_RDI,
		S_PAIR_RDJ,
		S_WRAP,
		S_CMP,
		S_DIV_GO,
		S_DIV_WAIT,
		S_POT,
		S_FRC_RDI,
		S_FRC_UPI,
		S_FRC_RDJ,
		S_FRC_UPJ,
		S_NEXT,
		S_DONE
	} st_t;

	typedef enum logic [3:0] {
		M_RC,
		M_SQ0,
		M_SQ1,
		M_SQ2,
		M_U2,
		M_U3,
		M_U4,
		M_U6,
		M_U7,
		M_VIR,
		M_F0,
		M_F1,
		M_F2
	} mstep_t;

	// {overflow, value}
	function automatic logic [64:0] sat_add(input logic [63:0] acc, input logic [63:0] mag,
			input logic neg);
		logic [63:0] b;
		logic [63:0] s;
		logic        ovf;
		b = neg ? (64'd0 - mag) : mag;
		s = acc + b;
		ovf = (acc[63] == b[63]) && (s[63] != acc[63]);
		if (ovf) begin
			return {1'b1, (acc[63] ? SIGN_BIT : MAG_LIMIT)};
		end
		return {1'b0, s};
	endfunction

	// {overflow, magnitude}: rescale to the accumulator fraction and clamp
	function automatic logic [64:0] to_acc(input logic [127:0] v, input int frac_in);
		int           s;
		logic [127:0] r;
		logic         ovf;
		s = frac_in - ACC_FRAC_BITS;
		if (s >= 0) begin
			r = v >> s;
		end else begin
			r = v << (-s);
		end
		ovf = ((v >> (63 + s)) != '0);
		if (ovf) begin
			return {1'b1, MAG_LIMIT};
		end
		return {1'b0, r[63:0]};
	endfunction

	// {overflow, value}: Q32.32 product, saturating
	function automatic logic [64:0] q32(input logic [127:0] p);
		if (p[127:96] != '0) begin
			return {1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
		end
		return {1'b0, p[95:32]};
	endfunction

	function automatic logic signed [35:0] wrap_d(input logic [31:0] a, input logic [31:0] b,
			input logic [30:0] side);
		logic signed [35:0] d;
		logic signed [35:0] sd;
		d  = 36'(signed'(a)) - 36'(signed'(b));
		sd = signed'({5'b0, side});
		if ((d <<< 1) < -sd) begin
			d = d + sd;
		end
		if ((d <<< 1) > sd) begin
			d = d - sd;
		end
		return d;
	endfunction

	function automatic logic [63:0] dmag(input logic [31:0] d);
		logic [31:0] m;
		m = d[31] ? (32'd0 - d) : d;
		return {32'd0, m};
	endfunction

endpackage

### sv/lj_mul.sv
`include "lennard_jones_pair_forces_defines.svh"

module lj_mul import lj_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [OP_W-1:0]     a,
	input  logic [OP_W-1:0]     b,
	output logic                done,
	output logic [PROD_W-1:0]   prod
);

	logic [OP_W-1:0]   a_q;
	logic [OP_W-1:0]   b_q;
	logic [2:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              pv_s1;
	logic [1:0]        k_s1;
	logic [63:0]       pp_s1;
	logic [PROD_W-1:0] acc_q;
	logic [31:0]       pa;
	logic [31:0]       pb;
	logic [PROD_W-1:0] addend;

	always_comb begin
		pa = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		pb = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		case (k_s1)
			2'd0:    addend = {64'd0, pp_s1};
			2'd3:    addend = {pp_s1, 64'd0};
			default: addend = {32'd0, pp_s1, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				pv_s1  <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				pv_s1 <= !cnt_q[2];
				if (cnt_q[2]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else begin
				pv_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + addend;
		end
		if (busy_q && !cnt_q[2]) begin
			pp_s1 <= 64'(pa * pb);
			k_s1  <= cnt_q[1:0];
		end
	end

	assign done = done_q;
	assign prod = acc_q;

	`LJ_ASSERT_IMPL(a_mul_start_idle, start, !busy_q, "multiplier started while busy")
	`LJ_ASSERT_NEXT(a_mul_done_after_last, busy_q && cnt_q == 3'd4, done_q, "product not flagged")
	`LJ_ASSERT_IMPL(a_mul_done_idle, done_q, !busy_q && !pv_s1, "done while still summing")

endmodule

### sv/lj_recip.sv
module lj_recip import lj_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OP_W-1:0] den,
	output logic            done,
	output logic [OP_W-1:0] quo
);

	logic [OP_W:0]   rem_q;
	logic [OP_W-1:0] q_q;
	logic [OP_W-1:0] den_q;
	logic [6:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [OP_W:0]   t;
	logic            ge;

	always_comb begin
		t  = {rem_q[OP_W-1:0], (cnt_q == 7'(OP_W))};
		ge = (t >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(OP_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (t - {1'b0, den_q}) : t;
			q_q   <= {q_q[OP_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

### sv/lennard_jones_pair_forces.sv
// Channel   Dir  Bits  Contents
// s_axis    in   304   tdata: index, pos_x/y/z, start_force_x/y/z; tuser: kind
// m_axis    out  336   tdata: out_index, force_x/y/z, potential, virial, saturated
// cfg       in   34    cfg_we, cfg_index (2), cfg_data (31)
// A write item is stored as it is taken in idle; a read item also waits for m_axis to be free.
// A compute item visits each pair; a pair is skipped when a distance component lies beyond 2^31, or
// when it lies outside the cutoff or at zero distance; within it, r2 of one LSB skips the reciprocal.
// One shared 32x32 multiplier, building each 64x64 product from partial products, and a serial reciprocal set the pace.
// No clearing pass after reset; stores hold garbage until written.
// s_axis_tready is low while a read or compute item is at work; m_axis stalls hold the result.
`include "lennard_jones_pair_forces_defines.svh"

module lennard_jones_pair_forces import lj_pkg::*; #(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [303:0] s_axis_tdata,  // index, pos_x, pos_y, pos_z, start_force_x/y/z, pad
	input  logic [1:0]   s_axis_tuser,  // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [335:0] m_axis_tdata,  // out_index, force_x/y/z, potential, virial, saturated
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_data
);

	localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

	st_t    st_q, st_d;
	mstep_t mstep_q;

	logic [10:0]  count_q;
	logic [30:0]  side_q;
	logic [30:0]  cut_q;
	logic [63:0]  rc2_q;
	logic [63:0]  pot_q;
	logic [63:0]  vir_q;
	logic         sat_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [IW:0]   n_c;
	logic [1:0]   ax_q;
	logic [95:0]  pi_q;
	logic [95:0]  prd_q;
	logic [191:0] frd_q;
	logic [31:0]  d_q [3];
	logic [63:0]  r2_q;
	logic [63:0]  u_q, u2_q, u3_q, u4_q, u6_q, u7_q;
	logic [63:0]  gmag_q;
	logic         gneg_q;
	logic [63:0]  m_q [3];
	logic         fneg_q [3];
	logic [9:0]   idx_q;
	logic         rd_ok_q;

	logic         out_valid_q;
	logic [9:0]   o_index_q;
	logic [63:0]  o_fx_q, o_fy_q, o_fz_q, o_pot_q, o_vir_q;
	logic         o_sat_q;

	logic [95:0]  pos_mem [MAX_PARTICLES];
	logic [191:0] frc_mem [MAX_PARTICLES];

	logic         in_acc;
	logic [1:0]   in_kind;
	logic [9:0]   in_index;
	logic [IW-1:0] in_addr;
	logic         in_ok;
	logic         out_free;
	logic         out_load;

	logic         pos_we, pos_re;
	logic [IW-1:0] pos_raddr;
	logic         frc_we, frc_re;
	logic [IW-1:0] frc_waddr, frc_raddr;
	logic [191:0] frc_wdata;

	logic         mul_start, mul_done;
	logic [63:0]  mul_a, mul_b;
	logic [127:0] mul_prod;
	logic [64:0]  mq;
	logic         div_start, div_done;
	logic [63:0]  div_quo;

	logic signed [35:0] wd;
	logic         far;
	logic [191:0] fupd;
	logic [2:0]   fovf;
	logic         upd_j;
	logic         pneg;
	logic [63:0]  pmag;
	logic [63:0]  hu4;
	logic         gneg_c;
	logic [63:0]  gmag_c;
	logic [64:0]  ta_pot, sp_pot, sp_zero, ta_mul, sv_vir;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign in_kind  = s_axis_tuser;
	assign in_index = s_axis_tdata[9:0];
	assign in_addr  = IW'(in_index);
	assign in_ok    = (32'(in_index) < 32'(MAX_PARTICLES));
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		if (32'(count_q) > 32'(MAX_PARTICLES)) begin
			n_c = (IW+1)'(MAX_PARTICLES);
		end else begin
			n_c = (IW+1)'(count_q);
		end
	end

	// datapath helpers
	always_comb begin
		wd  = wrap_d(pi_q[ax_q*32 +: 32], prd_q[ax_q*32 +: 32], side_q);
		far = !((wd[35:31] == 5'b00000) || ((wd[35:31] == 5'b11111) && (wd[30:0] != '0)));
		upd_j = (st_q == S_FRC_UPJ);
		for (int k = 0; k < 3; k++) begin
			{fovf[k], fupd[64*k +: 64]} = sat_add(frd_q[64*k +: 64], m_q[k], fneg_q[k] ^ upd_j);
		end
		pneg   = (u6_q < u3_q);
		pmag   = pneg ? (u3_q - u6_q) : (u6_q - u3_q);
		hu4    = u4_q >> 1;
		gneg_c = (u7_q < hu4);
		gmag_c = gneg_c ? (hu4 - u7_q) : (u7_q - hu4);
		ta_pot = to_acc({64'd0, pmag}, 32);
		sp_pot = sat_add(pot_q, ta_pot[63:0], pneg);
		sp_zero = sat_add(pot_q, MAG_LIMIT, 1'b0);
		mq     = q32(mul_prod);
		ta_mul = to_acc(mul_prod, (mstep_q == M_VIR) ? 64 : 48);
		sv_vir = sat_add(vir_q, ta_mul[63:0], !gneg_q);
	end

	always_comb begin
		unique case (mstep_q)
			M_RC: begin
				mul_a = {33'd0, cut_q};
				mul_b = {33'd0, cut_q};
			end
			M_SQ0: begin
				mul_a = dmag(d_q[0]);
				mul_b = dmag(d_q[0]);
			end
			M_SQ1: begin
				mul_a = dmag(d_q[1]);
				mul_b = dmag(d_q[1]);
			end
			M_SQ2: begin
				mul_a = dmag(d_q[2]);
				mul_b = dmag(d_q[2]);
			end
			M_U2: begin
				mul_a = u_q;
				mul_b = u_q;
			end
			M_U3: begin
				mul_a = u2_q;
				mul_b = u_q;
			end
			M_U4: begin
				mul_a = u2_q;
				mul_b = u2_q;
			end
			M_U6: begin
				mul_a = u2_q;
				mul_b = u4_q;
			end
			M_U7: begin
				mul_a = u6_q;
				mul_b = u_q;
			end
			M_VIR: begin
				mul_a = r2_q;
				mul_b = gmag_q;
			end
			M_F0: begin
				mul_a = dmag(d_q[0]);
				mul_b = gmag_q;
			end
			M_F1: begin
				mul_a = dmag(d_q[1]);
				mul_b = gmag_q;
			end
			M_F2: begin
				mul_a = dmag(d_q[2]);
				mul_b = gmag_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	lj_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	lj_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (r2_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (in_acc && in_kind == KIND_READ) begin
					st_d = S_READ_OUT;
				end else if (in_acc && in_kind == KIND_COMPUTE) begin
					st_d = S_PASS_INIT;
				end
			end
			S_READ_OUT: if (out_free) st_d = S_IDLE;
			S_PASS_INIT: st_d = S_MUL_GO;
			S_MUL_GO: st_d = S_MUL_WAIT;
			S_MUL_WAIT: begin
				if (mul_done) begin
					unique case (mstep_q)
						M_RC:  st_d = (n_c < (IW+1)'(2)) ? S_DONE : S_PAIR_RDI;
						M_SQ2: st_d = S_CMP;
						M_U7:  st_d = S_POT;
						M_F2:  st_d = S_FRC_RDI;
						default: st_d = S_MUL_GO;
					endcase
				end
			end
			S_PAIR_RDI: st_d = S_PAIR_RDJ;
			S_PAIR_RDJ: st_d = S_WRAP;
			S_WRAP: begin
				if (far) begin
					st_d = S_NEXT;
				end else if (ax_q == 2'd2) begin
					st_d = S_MUL_GO;
				end
			end
			S_CMP: begin
				if (r2_q > rc2_q || r2_q == 64'd0) begin
					st_d = S_NEXT;
				end else if (r2_q == 64'd1) begin
					st_d = S_MUL_GO;
				end else begin
					st_d = S_DIV_GO;
				end
			end
			S_DIV_GO: st_d = S_DIV_WAIT;
			S_DIV_WAIT: if (div_done) st_d = S_MUL_GO;
			S_POT: st_d = S_MUL_GO;
			S_FRC_RDI: st_d = S_FRC_UPI;
			S_FRC_UPI: st_d = S_FRC_RDJ;
			S_FRC_RDJ: st_d = S_FRC_UPJ;
			S_FRC_UPJ: st_d = S_NEXT;
			S_NEXT: begin
				if ((({1'b0, j_q} + 1'b1) < n_c) || (({1'b0, i_q} + (IW+1)'(2)) < n_c)) begin
					st_d = S_PAIR_RDI;
				end else begin
					st_d = S_DONE;
				end
			end
			S_DONE: if (out_free) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = 1'b0;
		pos_we    = 1'b0;
		pos_re    = 1'b0;
		pos_raddr = i_q;
		frc_we    = 1'b0;
		frc_waddr = i_q;
		frc_wdata = fupd;
		frc_re    = 1'b0;
		frc_raddr = i_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (in_acc && in_kind == KIND_WRITE && in_ok) begin
					pos_we    = 1'b1;
					frc_we    = 1'b1;
					frc_waddr = in_addr;
					frc_wdata = s_axis_tdata[297:106];
				end
				if (in_acc && in_kind == KIND_READ) begin
					frc_re    = 1'b1;
					frc_raddr = in_addr;
				end
			end
			S_READ_OUT, S_DONE: out_load = out_free;
			S_MUL_GO: mul_start = 1'b1;
			S_PAIR_RDI: pos_re = 1'b1;
			S_PAIR_RDJ: begin
				pos_re    = 1'b1;
				pos_raddr = j_q;
			end
			S_DIV_GO: div_start = 1'b1;
			S_FRC_RDI: frc_re = 1'b1;
			S_FRC_UPI: frc_we = 1'b1;
			S_FRC_RDJ: begin
				frc_re    = 1'b1;
				frc_raddr = j_q;
			end
			S_FRC_UPJ: begin
				frc_we    = 1'b1;
				frc_waddr = j_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[in_addr] <= s_axis_tdata[105:10];
		end
		if (pos_re) begin
			prd_q <= pos_mem[pos_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (frc_we) begin
			frc_mem[frc_waddr] <= frc_wdata;
		end
		if (frc_re) begin
			frd_q <= frc_mem[frc_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			mstep_q     <= M_RC;
			count_q     <= 11'd1024;
			side_q      <= 31'd655360;
			cut_q       <= 31'd163840;
			pot_q       <= '0;
			vir_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			ax_q        <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_COUNT:  count_q <= cfg_data[10:0];
					REG_BOX:    side_q  <= cfg_data;
					REG_CUTOFF: cut_q   <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_PASS_INIT: begin
					pot_q   <= '0;
					vir_q   <= '0;
					sat_q   <= 1'b0;
					mstep_q <= M_RC;
					i_q     <= '0;
					j_q     <= IW'(1);
				end
				S_PAIR_RDJ: ax_q <= '0;
				S_WRAP: begin
					ax_q    <= ax_q + 2'd1;
					mstep_q <= M_SQ0;
				end
				S_CMP: begin
					if (r2_q <= rc2_q && r2_q == 64'd0) begin
						sat_q <= 1'b1;
						pot_q <= sp_zero[63:0];
					end else if (r2_q <= rc2_q && r2_q == 64'd1) begin
						sat_q <= 1'b1;
					end
					mstep_q <= M_U2;
				end
				S_POT: begin
					pot_q   <= sp_pot[63:0];
					sat_q   <= sat_q | ta_pot[64] | sp_pot[64];
					mstep_q <= M_VIR;
				end
				S_MUL_WAIT: begin
					if (mul_done) begin
						unique case (mstep_q)
							M_RC:  mstep_q <= M_SQ0;
							M_SQ0: mstep_q <= M_SQ1;
							M_SQ1: mstep_q <= M_SQ2;
							M_U2:  mstep_q <= M_U3;
							M_U3:  mstep_q <= M_U4;
							M_U4:  mstep_q <= M_U6;
							M_U6:  mstep_q <= M_U7;
							M_VIR: mstep_q <= M_F0;
							M_F0:  mstep_q <= M_F1;
							M_F1:  mstep_q <= M_F2;
							default: ;
						endcase
						if (mstep_q == M_U2 || mstep_q == M_U3 || mstep_q == M_U4 ||
								mstep_q == M_U6 || mstep_q == M_U7) begin
							sat_q <= sat_q | mq[64];
						end
						if (mstep_q == M_VIR) begin
							vir_q <= sv_vir[63:0];
							sat_q <= sat_q | ta_mul[64] | sv_vir[64];
						end
						if (mstep_q == M_F0 || mstep_q == M_F1 || mstep_q == M_F2) begin
							sat_q <= sat_q | ta_mul[64];
						end
					end
				end
				S_FRC_UPI, S_FRC_UPJ: sat_q <= sat_q | (|fovf);
				S_NEXT: begin
					if (({1'b0, j_q} + 1'b1) < n_c) begin
						j_q <= j_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + IW'(2);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_PAIR_RDJ) begin
			pi_q <= prd_q;
			r2_q <= '0;
		end
		if (st_q == S_WRAP) begin
			d_q[ax_q] <= wd[31:0];
		end
		if (st_q == S_CMP && r2_q == 64'd1) begin
			u_q <= 64'hFFFF_FFFF_FFFF_FFFF;
		end
		if (st_q == S_DIV_WAIT && div_done) begin
			u_q <= div_quo;
		end
		if (st_q == S_POT) begin
			gmag_q <= gmag_c;
			gneg_q <= gneg_c;
		end
		if (st_q == S_MUL_WAIT && mul_done) begin
			unique case (mstep_q)
				M_RC:  rc2_q <= mul_prod[63:0];
				M_SQ0, M_SQ1, M_SQ2: r2_q <= r2_q + mul_prod[63:0];
				M_U2:  u2_q <= mq[63:0];
				M_U3:  u3_q <= mq[63:0];
				M_U4:  u4_q <= mq[63:0];
				M_U6:  u6_q <= mq[63:0];
				M_U7:  u7_q <= mq[63:0];
				M_F0: begin
					m_q[0]    <= ta_mul[63:0];
					fneg_q[0] <= d_q[0][31] ^ gneg_q;
				end
				M_F1: begin
					m_q[1]    <= ta_mul[63:0];
					fneg_q[1] <= d_q[1][31] ^ gneg_q;
				end
				M_F2: begin
					m_q[2]    <= ta_mul[63:0];
					fneg_q[2] <= d_q[2][31] ^ gneg_q;
				end
				default: ;
			endcase
		end
		if (in_acc && in_kind == KIND_READ) begin
			idx_q   <= in_index;
			rd_ok_q <= in_ok;
		end
		if (out_load) begin
			o_pot_q <= pot_q;
			o_vir_q <= vir_q;
			o_sat_q <= sat_q;
			if (st_q == S_READ_OUT) begin
				o_index_q <= idx_q;
				o_fx_q    <= rd_ok_q ? frd_q[63:0]    : 64'd0;
				o_fy_q    <= rd_ok_q ? frd_q[127:64]  : 64'd0;
				o_fz_q    <= rd_ok_q ? frd_q[191:128] : 64'd0;
			end else begin
				o_index_q <= '0;
				o_fx_q    <= '0;
				o_fy_q    <= '0;
				o_fz_q    <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, o_sat_q, o_vir_q, o_pot_q, o_fz_q, o_fy_q, o_fx_q, o_index_q};

	`LJ_ASSERT_IMPL(a_no_overwrite, out_load, !out_valid_q || m_axis_tready, "result overwritten")
	`LJ_ASSERT_IMPL(a_pair_order, st_q == S_PAIR_RDI, j_q > i_q, "pair visited with j not above i")
	`LJ_ASSERT_IMPL(a_mul_done_waited, mul_done, st_q == S_MUL_WAIT, "product arrived unexpected")

endmodule
